/* hdl/local_binary_pattern_3x3_macros.svh */
// ----------------------------------------------------------------------------
// local_binary_pattern_3x3 assertion macros
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LOCAL_BINARY_PATTERN_3X3_MACROS_SVH
`define LOCAL_BINARY_PATTERN_3X3_MACROS_SVH

// same-cycle implication
`define LBP3_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LBP3_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/lbp3_pkg.sv */
// ----------------------------------------------------------------------------
// lbp3_pkg
// Types and constants shared by the 3x3 local binary pattern block.
// ----------------------------------------------------------------------------
package lbp3_pkg;

	localparam int PIX_W        = 8;
	localparam int IMG_W_W      = 12;
	localparam int IMG_H_W      = 13;
	localparam int ROW_W        = 12;
	localparam int CFG_DATA_W   = 13;
	localparam int HEIGHT_LIMIT = 4096;

	typedef logic [PIX_W-1:0]      pixel_t;
	typedef logic [PIX_W-1:0]      code_t;
	typedef logic [IMG_W_W-1:0]    img_width_t;
	typedef logic [IMG_H_W-1:0]    img_height_t;
	typedef logic [ROW_W-1:0]      row_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	typedef enum logic [1:0] {
		REG_IMAGE_WIDTH     = 2'd0,
		REG_IMAGE_HEIGHT    = 2'd1,
		REG_THRESHOLD_LEVEL = 2'd2,
		REG_TOZERO_ENABLE   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		pixel_t threshold_level;
		logic   tozero_enable;
		row_t   height_last;
	} pix_cfg_t;

endpackage

/* hdl/lbp3_if.sv */
// ----------------------------------------------------------------------------
// lbp3 interfaces
// Pixel, code and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lbp3_pix_if;
	import lbp3_pkg::*;
	logic   valid;
	logic   ready;
	pixel_t pixel;
	logic   frame_start;
	modport src (output valid, pixel, frame_start, input ready);
	modport snk (input valid, pixel, frame_start, output ready);
endinterface

interface lbp3_code_if;
	import lbp3_pkg::*;
	logic  valid;
	logic  ready;
	code_t pattern_code;
	logic  row_end;
	logic  frame_end;
	modport src (output valid, pattern_code, row_end, frame_end, input ready);
	modport snk (input valid, pattern_code, row_end, frame_end, output ready);
endinterface

interface lbp3_cfg_if;
	import lbp3_pkg::*;
	logic      valid;
	logic      ready;
	cfg_reg_t  index;
	cfg_data_t data;
	modport src (output valid, index, data, input ready);
	modport snk (input valid, index, data, output ready);
endinterface

/* hdl/lbp3_cfg.sv */
// ----------------------------------------------------------------------------
// lbp3_cfg
// Configuration registers and clamped frame geometry.
// ----------------------------------------------------------------------------
module lbp3_cfg #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                         clk,
	input  logic                         arst_n,
	lbp3_cfg_if.snk                      cfg,
	output logic [$clog2(MAX_WIDTH)-1:0] width_last,
	output lbp3_pkg::pix_cfg_t           pcfg
);
	import lbp3_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	img_width_t  width_q;
	img_height_t height_q;
	pixel_t      level_q;
	logic        enable_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= IMG_W_W'(2048);
			height_q <= IMG_H_W'(4096);
			level_q  <= PIX_W'(1);
			enable_q <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_IMAGE_WIDTH:     width_q  <= cfg.data[IMG_W_W-1:0];
				REG_IMAGE_HEIGHT:    height_q <= cfg.data[IMG_H_W-1:0];
				REG_THRESHOLD_LEVEL: level_q  <= cfg.data[PIX_W-1:0];
				REG_TOZERO_ENABLE:   enable_q <= cfg.data[0];
			endcase
		end
	end

	always_comb begin
		priority if (width_q < IMG_W_W'(3)) begin
			width_last = CW'(2);
		end else if (32'(width_q) > MAX_WIDTH) begin
			width_last = CW'(MAX_WIDTH - 1);
		end else begin
			width_last = CW'(width_q - IMG_W_W'(1));
		end
	end

	always_comb begin
		pcfg.threshold_level = level_q;
		pcfg.tozero_enable   = enable_q;
		priority if (height_q < IMG_H_W'(3)) begin
			pcfg.height_last = ROW_W'(2);
		end else if (height_q > IMG_H_W'(HEIGHT_LIMIT)) begin
			pcfg.height_last = ROW_W'(HEIGHT_LIMIT - 1);
		end else begin
			pcfg.height_last = ROW_W'(height_q - IMG_H_W'(1));
		end
	end

endmodule

/* hdl/lbp3_line_store.sv */
// ----------------------------------------------------------------------------
// lbp3_line_store
// Two line buffers in one memory; a fill mark makes unwritten columns read 0.
// A write to the column being read in the same cycle is forwarded.
// ----------------------------------------------------------------------------
module lbp3_line_store #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
	input  logic                         wr_en,
	input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
	input  lbp3_pkg::pixel_t             wr_upper,
	input  lbp3_pkg::pixel_t             wr_middle,
	output lbp3_pkg::pixel_t             rd_upper,
	output lbp3_pkg::pixel_t             rd_middle
);
	import lbp3_pkg::*;

	localparam int FW = $clog2(MAX_WIDTH + 1);

	logic [2*PIX_W-1:0] mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] rd_q;
	logic [2*PIX_W-1:0] fwd_data_q;
	logic [2*PIX_W-1:0] rd_word;
	logic [FW-1:0]      fill_q;
	logic               hit_q;
	logic               fwd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_upper, wr_middle};
		end
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			fwd_data_q <= {wr_upper, wr_middle};
		end
	end

	// columns are first visited in order 0,1,2..., so one mark covers both lines
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			hit_q  <= 1'b0;
			fwd_q  <= 1'b0;
		end else if (rd_en) begin
			hit_q <= FW'(rd_addr) < fill_q;
			fwd_q <= wr_en && (wr_addr == rd_addr);
			if (FW'(rd_addr) == fill_q && fill_q != FW'(MAX_WIDTH)) begin
				fill_q <= fill_q + FW'(1);
			end
		end
	end

	assign rd_word   = fwd_q ? fwd_data_q : (hit_q ? rd_q : '0);
	assign rd_upper  = rd_word[2*PIX_W-1:PIX_W];
	assign rd_middle = rd_word[PIX_W-1:0];

endmodule

/* hdl/lbp3_window.sv */
// ----------------------------------------------------------------------------
// lbp3_window
// Two stored window columns plus the incoming column; neighbour compare.
// ----------------------------------------------------------------------------
module lbp3_window (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift,
	input  lbp3_pkg::pixel_t top,
	input  lbp3_pkg::pixel_t mid,
	input  lbp3_pkg::pixel_t bot,
	output lbp3_pkg::code_t  code_word
);
	import lbp3_pkg::*;

	pixel_t win_q [6];
	pixel_t centre;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (shift) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top;
			win_q[4] <= mid;
			win_q[5] <= bot;
		end
	end

	assign centre = win_q[4];

	// bit 7 top-left, clockwise, bit 0 left
	assign code_word = {win_q[0] > centre, win_q[3] > centre, top > centre,
	                    mid > centre, bot > centre, win_q[5] > centre,
	                    win_q[2] > centre, win_q[1] > centre};

endmodule

/* hdl/local_binary_pattern_3x3.sv */
// ----------------------------------------------------------------------------
// local_binary_pattern_3x3
// A pixel word passes the stage-1 register, then the output code register.
// Throughput unless stalled: 1 pixel word, 1 line store read, 1 write a cycle.
// Reset: counters, window and line store fill mark clear at once; no sweep.
// Configuration registers return to width 2048, height 4096, level 1, enabled.
// ----------------------------------------------------------------------------
module local_binary_pattern_3x3 #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic     clk,
	input  logic     arst_n,
	lbp3_pix_if.snk  pix,
	lbp3_code_if.src code,
	lbp3_cfg_if.snk  cfg
);
	import lbp3_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	logic [CW-1:0] width_last;
	pix_cfg_t      pcfg;

	logic          acc;
	logic          out_free;
	logic          adv_s1;
	logic [CW-1:0] c0;
	row_t          r0;
	pixel_t        p0;
	logic          col_wrap;
	logic          row_wrap;

	logic [CW-1:0] col_q;
	row_t          row_q;

	logic          v_s1;
	pixel_t        pix_s1;
	logic [CW-1:0] col_s1;
	logic          emit_s1;
	logic          row_end_s1;
	logic          frame_end_s1;

	pixel_t        top;
	pixel_t        mid;
	code_t         code_word;

	logic          out_v_q;
	code_t         code_q;
	logic          row_end_q;
	logic          frame_end_q;

	lbp3_cfg #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.width_last (width_last),
		.pcfg       (pcfg)
	);

	assign out_free  = !out_v_q || code.ready;
	assign pix.ready = !v_s1 || out_free;
	assign acc       = pix.valid && pix.ready;
	assign adv_s1    = v_s1 && out_free;

	assign c0 = pix.frame_start ? '0 : col_q;
	assign r0 = pix.frame_start ? '0 : row_q;
	assign p0 = (pcfg.tozero_enable && pix.pixel <= pcfg.threshold_level) ? '0 : pix.pixel;

	assign col_wrap = c0 >= width_last;
	assign row_wrap = r0 >= pcfg.height_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : r0 + ROW_W'(1);
			end else begin
				col_q <= c0 + CW'(1);
				row_q <= r0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pix.ready) begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1       <= p0;
			col_s1       <= c0;
			emit_s1      <= (r0 >= ROW_W'(2)) && (c0 >= CW'(2));
			row_end_s1   <= c0 == width_last;
			frame_end_s1 <= (c0 == width_last) && (r0 == pcfg.height_last);
		end
	end

	lbp3_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_line_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (acc),
		.rd_addr   (c0),
		.wr_en     (adv_s1),
		.wr_addr   (col_s1),
		.wr_upper  (mid),
		.wr_middle (pix_s1),
		.rd_upper  (top),
		.rd_middle (mid)
	);

	lbp3_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.shift     (adv_s1),
		.top       (top),
		.mid       (mid),
		.bot       (pix_s1),
		.code_word (code_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= adv_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			code_q      <= code_word;
			row_end_q   <= row_end_s1;
			frame_end_q <= frame_end_s1;
		end
	end

	assign code.valid        = out_v_q;
	assign code.pattern_code = code_q;
	assign code.row_end      = row_end_q;
	assign code.frame_end    = frame_end_q;

endmodule

/* hdl/lbp3_checker.sv */
// ----------------------------------------------------------------------------
// lbp3_checker
// Port-level checks for local_binary_pattern_3x3, bound to the top level.
// ----------------------------------------------------------------------------
`include "local_binary_pattern_3x3_macros.svh"

module lbp3_checker (
	input logic clk,
	input logic arst_n,
	input logic pix_valid,
	input logic pix_ready,
	input logic code_valid,
	input logic code_ready,
	input logic code_row_end,
	input logic code_frame_end
);

	`LBP3_ASSERT_NEXT(a_code_hold, code_valid && !code_ready, code_valid, "code word dropped while stalled")

	`LBP3_ASSERT_NOW(a_frame_end_row_end, code_valid && code_frame_end, code_row_end, "frame_end without row_end")

	`LBP3_ASSERT_NOW(a_code_needs_pixel, $rose(code_valid), $past(pix_valid && pix_ready, 2), "code word without pixel word two cycles earlier")

	`LBP3_ASSERT_NOW(a_one_word_in_flight, (code_valid && !code_ready && pix_valid && pix_ready) ##1 (code_valid && !code_ready), !pix_ready, "more than one pixel word taken under output stall")

endmodule

bind local_binary_pattern_3x3 lbp3_checker u_lbp3_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.pix_valid      (pix.valid),
	.pix_ready      (pix.ready),
	.code_valid     (code.valid),
	.code_ready     (code.ready),
	.code_row_end   (code.row_end),
	.code_frame_end (code.frame_end)
);

/* tb/sv/local_binary_pattern_3x3_tb.sv */
// ----------------------------------------------------------------------------
// local_binary_pattern_3x3_tb
// Streams raster frames of pixel words through the 3x3 local binary pattern
// block under random source and sink stalls. Each accepted pixel word feeds a
// local model of the line stores, window and position counters; every code
// word that leaves the block is checked against the oldest predicted word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module local_binary_pattern_3x3_tb;
	import lbp3_pkg::*;

	localparam int MAX_W  = 2048;
	localparam int SETTLE = 8;
	localparam int LIMIT  = 400000;

	typedef struct {
		pixel_t value;
		logic   first;
	} pix_word_t;

	typedef struct {
		cfg_reg_t  index;
		cfg_data_t data;
	} reg_word_t;

	typedef struct packed {
		code_t pattern_code;
		logic  row_end;
		logic  frame_end;
	} code_word_t;

	logic clk;
	logic arst_n;

	lbp3_pix_if  pix();
	lbp3_code_if code();
	lbp3_cfg_if  cfg();

	local_binary_pattern_3x3 #(
		.MAX_WIDTH(MAX_W)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.code   (code),
		.cfg    (cfg)
	);

	pix_word_t  pixel_feed[$];
	reg_word_t  reg_writes[$];
	code_word_t pending_codes[$];

	// model of the block
	pixel_t      prev2_row[MAX_W];
	pixel_t      prev1_row[MAX_W];
	pixel_t      win_px[6];
	int unsigned col_at;
	int unsigned row_at;
	img_width_t  cur_width;
	img_height_t cur_height;
	pixel_t      cur_level;
	logic        cur_enable;

	int unsigned src_idle_pct;
	int unsigned dst_idle_pct;
	int unsigned fail_count = 0;
	int unsigned cycles = 0;
	int unsigned rand_items = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic int unsigned eff_dim(int unsigned v, int unsigned hi);
		if (v < 3)
			return 3;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic void apply_reg(cfg_reg_t idx, cfg_data_t v);
		unique case (idx)
			REG_IMAGE_WIDTH:     cur_width  = v[IMG_W_W-1:0];
			REG_IMAGE_HEIGHT:    cur_height = v[IMG_H_W-1:0];
			REG_THRESHOLD_LEVEL: cur_level  = v[PIX_W-1:0];
			REG_TOZERO_ENABLE:   cur_enable = v[0];
		endcase
	endfunction

	task automatic lbp_step(input pixel_t px_in, input logic first);
		int unsigned w_eff;
		int unsigned h_eff;
		int unsigned c;
		int unsigned r;
		pixel_t      p;
		pixel_t      top;
		pixel_t      mid;
		pixel_t      ctr;
		code_word_t  cw;
		w_eff = eff_dim(cur_width, MAX_W);
		h_eff = eff_dim(cur_height, HEIGHT_LIMIT);
		if (first) begin
			col_at = 0;
			row_at = 0;
		end
		p = px_in;
		if (cur_enable && p <= cur_level)
			p = '0;
		c = col_at;
		r = row_at;
		top = prev2_row[c % MAX_W];
		mid = prev1_row[c % MAX_W];
		prev2_row[c % MAX_W] = mid;
		prev1_row[c % MAX_W] = p;
		if (r >= 2 && c >= 2) begin
			ctr = win_px[4];
			cw.pattern_code = {win_px[0] > ctr, win_px[3] > ctr, top > ctr, mid > ctr,
				p > ctr, win_px[5] > ctr, win_px[2] > ctr, win_px[1] > ctr};
			cw.row_end   = (c == w_eff - 1);
			cw.frame_end = (c == w_eff - 1) && (r == h_eff - 1);
			pending_codes.insert(pending_codes.size(), cw);
		end
		win_px[0] = win_px[3];
		win_px[1] = win_px[4];
		win_px[2] = win_px[5];
		win_px[3] = top;
		win_px[4] = mid;
		win_px[5] = p;
		if (c + 1 >= w_eff) begin
			col_at = 0;
			row_at = (r + 1 >= h_eff) ? 0 : r + 1;
		end else begin
			col_at = c + 1;
		end
	endtask

	// pixel word source
	always @(posedge clk) begin : drive_pix
		pix_word_t pw;
		if (arst_n && (!pix.valid || pix.ready)) begin
			if (pixel_feed.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				pw = pixel_feed.pop_front();
				pix.valid       <= 1'b1;
				pix.pixel       <= pw.value;
				pix.frame_start <= pw.first;
			end else begin
				pix.valid <= 1'b0;
			end
		end
	end

	// register write source
	always @(posedge clk) begin : drive_cfg
		reg_word_t rw;
		if (arst_n && (!cfg.valid || cfg.ready)) begin
			if (reg_writes.size() != 0) begin
				rw = reg_writes.pop_front();
				cfg.valid <= 1'b1;
				cfg.index <= rw.index;
				cfg.data  <= rw.data;
			end else begin
				cfg.valid <= 1'b0;
			end
		end
	end

	// code word sink
	always @(posedge clk) begin
		if (arst_n)
			code.ready <= ($urandom_range(99) >= dst_idle_pct);
	end

	always @(posedge clk) begin : watch
		code_word_t got;
		code_word_t want;
		if (arst_n) begin
			if (cfg.valid && cfg.ready)
				apply_reg(cfg.index, cfg.data);
			if (pix.valid && pix.ready)
				lbp_step(pix.pixel, pix.frame_start);
			if (code.valid && code.ready) begin
				got = {code.pattern_code, code.row_end, code.frame_end};
				if (pending_codes.size() == 0) begin
					$display("%0t: unexpected code word, actual %h/%b/%b", $time,
						got.pattern_code, got.row_end, got.frame_end);
					fail_count++;
				end else begin
					want = pending_codes.pop_front();
					if (got !== want) begin
						$display("%0t: code word mismatch, expected %h/%b/%b, actual %h/%b/%b",
							$time, want.pattern_code, want.row_end, want.frame_end,
							got.pattern_code, got.row_end, got.frame_end);
						fail_count++;
					end
				end
			end
		end
	end

	task automatic set_reg(cfg_reg_t idx, int unsigned v);
		reg_word_t rw;
		rw.index = idx;
		rw.data  = cfg_data_t'(v);
		reg_writes.insert(reg_writes.size(), rw);
	endtask

	task automatic commit_regs();
		while (reg_writes.size() != 0 || cfg.valid)
			@(negedge clk);
	endtask

	task automatic push_px(pixel_t v, logic first);
		pix_word_t pw;
		pw.value = v;
		pw.first = first;
		pixel_feed.insert(pixel_feed.size(), pw);
	endtask

	function automatic pixel_t pick_pixel(int unsigned style);
		if (style == 0)
			return pixel_t'($urandom_range(255));
		unique case ($urandom_range(4))
			0:       return '0;
			1:       return cur_level;
			2:       return cur_level + 1'b1;
			3:       return 8'hff;
			default: return pixel_t'($urandom_range(255));
		endcase
	endfunction

	task automatic push_run(int unsigned n, logic first, int unsigned style);
		for (int unsigned i = 0; i < n; i++)
			push_px(pick_pixel(style), first && i == 0);
	endtask

	function automatic int unsigned pick_dim(int unsigned typ_hi, int unsigned far_hi);
		int unsigned k;
		k = $urandom_range(9);
		if (k == 0)
			return $urandom_range(2);
		if (k == 1)
			return $urandom_range(far_hi, typ_hi + 1);
		return $urandom_range(typ_hi, 3);
	endfunction

	task automatic drain();
		while (pixel_feed.size() != 0 || pix.valid || pending_codes.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	initial begin : stim
		pixel_t      dir_px[9];
		int unsigned w_eff;
		int unsigned h_eff;
		int unsigned n;
		int unsigned kind;
		int unsigned style;
		int unsigned nfr;

		arst_n          = 1'b0;
		pix.valid       = 1'b0;
		pix.pixel       = '0;
		pix.frame_start = 1'b0;
		code.ready      = 1'b0;
		cfg.valid       = 1'b0;
		cfg.index       = REG_IMAGE_WIDTH;
		cfg.data        = '0;
		cur_width       = 12'd2048;
		cur_height      = 13'd4096;
		cur_level       = 8'd1;
		cur_enable      = 1'b1;
		for (int i = 0; i < MAX_W; i++) begin
			prev2_row[i] = '0;
			prev1_row[i] = '0;
		end
		for (int i = 0; i < 6; i++)
			win_px[i] = '0;
		col_at       = 0;
		row_at       = 0;
		src_idle_pct = 15;
		dst_idle_pct = 48;

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// width, level and enable left at their reset values
		set_reg(REG_IMAGE_HEIGHT, 3);
		commit_regs();
		push_run(32, 1'b1, 0);
		drain();

		// level boundary, ties, both extremes of the pixel
		set_reg(REG_IMAGE_WIDTH, 3);
		set_reg(REG_IMAGE_HEIGHT, 3);
		set_reg(REG_THRESHOLD_LEVEL, 100);
		set_reg(REG_TOZERO_ENABLE, 1);
		commit_regs();
		dir_px = '{8'd255, 8'd100, 8'd101, 8'd0, 8'd101, 8'd200, 8'd100, 8'd102, 8'd255};
		foreach (dir_px[i])
			push_px(dir_px[i], i == 0);
		drain();

		// bypass, then a frame abandoned and restarted in mid-frame
		set_reg(REG_TOZERO_ENABLE, 0);
		set_reg(REG_THRESHOLD_LEVEL, 255);
		commit_regs();
		push_run(4, 1'b1, 0);
		dir_px = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd0, 8'd255, 8'd5, 8'd6, 8'd7};
		foreach (dir_px[i])
			push_px(dir_px[i], i == 0);
		drain();

		while (rand_items < 240) begin
			if (rand_items < 80) begin
				src_idle_pct = 15;
				dst_idle_pct = 48;
			end else if (rand_items < 160) begin
				src_idle_pct = 48;
				dst_idle_pct = 15;
			end else begin
				src_idle_pct = 0;
				dst_idle_pct = 0;
			end
			drain();
			if ($urandom_range(9) < 7)
				set_reg(REG_IMAGE_WIDTH, pick_dim(8, 16));
			if ($urandom_range(9) < 7)
				set_reg(REG_IMAGE_HEIGHT, pick_dim(6, 10));
			if ($urandom_range(9) < 7)
				set_reg(REG_THRESHOLD_LEVEL,
					$urandom_range(1) ? $urandom_range(255) : $urandom_range(40));
			if ($urandom_range(9) < 7)
				set_reg(REG_TOZERO_ENABLE, $urandom_range(1));
			commit_regs();
			w_eff = eff_dim(cur_width, MAX_W);
			h_eff = eff_dim(cur_height, HEIGHT_LIMIT);
			nfr   = $urandom_range(3, 1);
			repeat (nfr) begin
				kind  = $urandom_range(9);
				style = $urandom_range(1);
				case (kind)
					0: begin
						// broken frame, cut short
						n = $urandom_range(w_eff * h_eff - 1, 1);
						push_run(n, 1'b1, style);
					end
					1: begin
						// noise with stray frame starts
						n = $urandom_range(20, 5);
						for (int unsigned i = 0; i < n; i++)
							push_px(pick_pixel(style), $urandom_range(9) == 0);
					end
					2: begin
						// no frame start, relies on the position wrap
						n = w_eff * h_eff;
						push_run(n, 1'b0, style);
					end
					default: begin
						n = w_eff * h_eff;
						push_run(n, 1'b1, style);
					end
				endcase
				rand_items += n;
			end
		end
		drain();

		// oversized width, all pixels forced to zero
		set_reg(REG_IMAGE_WIDTH, 4095);
		set_reg(REG_IMAGE_HEIGHT, 3);
		set_reg(REG_THRESHOLD_LEVEL, 255);
		set_reg(REG_TOZERO_ENABLE, 1);
		commit_regs();
		push_run(32, 1'b1, 1);
		drain();

		// undersized width, oversized height
		set_reg(REG_IMAGE_WIDTH, 2);
		set_reg(REG_IMAGE_HEIGHT, 8191);
		set_reg(REG_THRESHOLD_LEVEL, 0);
		commit_regs();
		push_run(3 * 24, 1'b1, 0);
		drain();

		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* files.f */
+incdir+hdl
hdl/lbp3_pkg.sv
hdl/lbp3_if.sv
hdl/lbp3_cfg.sv
hdl/lbp3_line_store.sv
hdl/lbp3_window.sv
hdl/local_binary_pattern_3x3.sv
hdl/lbp3_checker.sv
tb/sv/local_binary_pattern_3x3_tb.sv
